/* hdl/ardf_pkg.sv */
// Shared constants, types and key functions of the array row distinct filter.
`default_nettype none

package ardf_pkg;

    // Key store geometry
    localparam int SET_DEPTH = 64;
    localparam int IDX_W     = $clog2(SET_DEPTH);
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int KEY_W     = 64;
    localparam int OFS_W     = 32;
    localparam int ET_W      = 3;
    localparam int CMD_W     = 2;

    // Element type codes; the unused code compares like long
    localparam logic [ET_W-1:0] ET_BYTE   = 3'd0;
    localparam logic [ET_W-1:0] ET_SHORT  = 3'd1;
    localparam logic [ET_W-1:0] ET_INT    = 3'd2;
    localparam logic [ET_W-1:0] ET_LONG   = 3'd3;
    localparam logic [ET_W-1:0] ET_FLOAT  = 3'd4;
    localparam logic [ET_W-1:0] ET_DOUBLE = 3'd5;
    localparam logic [ET_W-1:0] ET_BOOL   = 3'd6;
    localparam logic [ET_W-1:0] ET_RESET  = ET_INT;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ELEM  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NULL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } ardf_state_t;

    // Decision held for the item in flight until it is committed
    typedef struct packed {
        logic has;
        logic is_null;
        logic rend;
        logic rnull;
        logic ovf;
        logic store;
    } ardf_pend_t;

    // Compare width per element type
    function automatic logic [KEY_W-1:0] width_mask(input logic [ET_W-1:0] et);
        logic [KEY_W-1:0] m;
        unique case (et)
            ET_BYTE:            m = 64'h0000_0000_0000_00FF;
            ET_SHORT:           m = 64'h0000_0000_0000_FFFF;
            ET_INT, ET_FLOAT:   m = 64'h0000_0000_FFFF_FFFF;
            ET_BOOL:            m = 64'h0000_0000_0000_0001;
            default:            m = '1;
        endcase
        return m;
    endfunction

    // Normalise a value to its compare key: fold NaNs together and -0 onto +0
    function automatic logic [KEY_W-1:0] make_key(input logic [ET_W-1:0] et,
                                                  input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] k;
        k = v & width_mask(et);
        if (et == ET_FLOAT) begin
            if (k[30:23] == 8'hFF && k[22:0] != 23'd0) begin
                k = 64'h0000_0000_7FC0_0000;
            end
            else if (k == 64'h0000_0000_8000_0000) begin
                k = '0;
            end
        end
        else if (et == ET_DOUBLE) begin
            if (k[62:52] == 11'h7FF && k[51:0] != 52'd0) begin
                k = 64'h7FF8_0000_0000_0000;
            end
            else if (k == 64'h8000_0000_0000_0000) begin
                k = '0;
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/ardf_in_if.sv */
// Input channel: one array element or row command per transfer.
`default_nettype none

interface ardf_in_if;
    logic                         valid;
    logic                         ready;
    logic [ardf_pkg::CMD_W-1:0]   cmd;
    logic                         elem_null;
    logic [ardf_pkg::KEY_W-1:0]   elem_value;
    logic                         row_last;

    modport source (output valid, output cmd, output elem_null, output elem_value,
                    output row_last, input ready);
    modport sink   (input valid, input cmd, input elem_null, input elem_value,
                    input row_last, output ready);
endinterface

`default_nettype wire

/* hdl/ardf_out_if.sv */
// Output channel: one filtered element and/or row end per transfer.
`default_nettype none

interface ardf_out_if;
    logic                         valid;
    logic                         ready;
    logic                         has_element;
    logic [ardf_pkg::KEY_W-1:0]   out_value;
    logic                         out_null;
    logic                         row_end;
    logic                         row_is_null;
    logic [ardf_pkg::OFS_W-1:0]   end_offset;
    logic                         set_overflow;

    modport source (output valid, output has_element, output out_value, output out_null,
                    output row_end, output row_is_null, output end_offset,
                    output set_overflow, input ready);
    modport sink   (input valid, input has_element, input out_value, input out_null,
                    input row_end, input row_is_null, input end_offset,
                    input set_overflow, output ready);
endinterface

`default_nettype wire

/* hdl/ardf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ardf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/array_row_distinct_filter.sv */
// Top level of the array row distinct filter.
`default_nettype none

// Passes on the first occurrence of each value within an array row, one element per
// input transfer. Keys of the open row are kept in a 64-entry RAM and searched one
// entry per cycle through its single read port; a match ends the scan early. Row
// commands, null elements and the first element of a row need no scan, and an ignored
// command leaves the block idle. Input is taken only while the block is idle, so a new
// item waits until the last one is done. A result waits in an output register; further
// input is also held back while that register is still full when the next result is
// ready. Write element_type only while the block is idle.
module array_row_distinct_filter (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ardf_pkg::ET_W-1:0]   cfg_wdata,
    ardf_in_if.sink                          in_ch,
    ardf_out_if.source                       out_ch
);

    ardf_pkg::ardf_state_t               state_reg, state_next;
    logic [ardf_pkg::ET_W-1:0]           etype_reg;
    logic [ardf_pkg::CNT_W-1:0]          seen_count_reg, seen_count_next;
    logic                                null_seen_reg, null_seen_next;
    logic [ardf_pkg::OFS_W-1:0]          offset_reg, offset_next;
    logic [ardf_pkg::CNT_W-1:0]          rd_idx_reg, rd_idx_next;
    logic                                cmp_pend_reg, cmp_pend_next;
    logic [ardf_pkg::KEY_W-1:0]          key_reg, key_next;
    logic [ardf_pkg::KEY_W-1:0]          val_reg, val_next;
    ardf_pkg::ardf_pend_t                pend_reg, pend_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                out_has_reg, out_has_next;
    logic [ardf_pkg::KEY_W-1:0]          out_value_reg, out_value_next;
    logic                                out_null_reg, out_null_next;
    logic                                out_rend_reg, out_rend_next;
    logic                                out_rnull_reg, out_rnull_next;
    logic [ardf_pkg::OFS_W-1:0]          out_offset_reg, out_offset_next;
    logic                                out_ovf_reg, out_ovf_next;

    logic                                accept;
    logic                                full;
    logic                                match;
    logic                                scan_end;
    logic                                has_res;
    logic                                commit;
    logic                                search_start;
    logic                                ram_we;
    logic                                ram_re;
    logic [ardf_pkg::KEY_W-1:0]          ram_rdata;

    // Status of the item in flight
    assign accept       = in_ch.valid && in_ch.ready;
    assign full         = (seen_count_reg == ardf_pkg::CNT_W'(ardf_pkg::SET_DEPTH));
    assign match        = cmp_pend_reg && (ram_rdata == key_reg);
    assign scan_end     = cmp_pend_reg && !match && (rd_idx_reg == seen_count_reg);
    assign has_res      = pend_reg.has || pend_reg.rend;
    assign commit       = (state_reg == ardf_pkg::ST_FINISH)
                          && (!has_res || !out_valid_reg || out_ch.ready);
    assign search_start = accept && (in_ch.cmd == ardf_pkg::CMD_ELEM) && !in_ch.elem_null
                          && (seen_count_reg != '0);

    // Key store
    ardf_ram #(
        .WIDTH (ardf_pkg::KEY_W),
        .DEPTH (ardf_pkg::SET_DEPTH)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (seen_count_reg[ardf_pkg::IDX_W-1:0]),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (rd_idx_reg[ardf_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ardf_pkg::ST_IDLE:
            begin
                if (accept && in_ch.cmd != ardf_pkg::CMD_NONE)
                begin
                    state_next = search_start ? ardf_pkg::ST_SEARCH : ardf_pkg::ST_FINISH;
                end
            end
            ardf_pkg::ST_SEARCH:
            begin
                if (match || scan_end)
                begin
                    state_next = ardf_pkg::ST_FINISH;
                end
            end
            ardf_pkg::ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ardf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ardf_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs
    always_comb
    begin
        in_ch.ready = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        unique case (state_reg)
            ardf_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            ardf_pkg::ST_SEARCH:
            begin
                ram_re = (rd_idx_reg < seen_count_reg) && !match;
            end
            ardf_pkg::ST_FINISH:
            begin
                ram_we = commit && pend_reg.store;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    // Item decision, key scan and row state
    always_comb
    begin
        key_next        = key_reg;
        val_next        = val_reg;
        pend_next       = pend_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_pend_next   = 1'b0;
        seen_count_next = seen_count_reg;
        null_seen_next  = null_seen_reg;
        offset_next     = offset_reg;

        // Latch the item and settle everything that needs no scan
        if (accept)
        begin
            key_next        = ardf_pkg::make_key(etype_reg, in_ch.elem_value);
            val_next        = in_ch.elem_value & ardf_pkg::width_mask(etype_reg);
            pend_next       = '0;
            pend_next.rnull = (in_ch.cmd == ardf_pkg::CMD_NULL);
            pend_next.rend  = (in_ch.cmd == ardf_pkg::CMD_ELEM) ? in_ch.row_last : 1'b1;
            rd_idx_next     = '0;
            if (in_ch.cmd == ardf_pkg::CMD_ELEM)
            begin
                if (in_ch.elem_null)
                begin
                    pend_next.has     = !null_seen_reg;
                    pend_next.is_null = !null_seen_reg;
                end
                else if (seen_count_reg == '0)
                begin
                    pend_next.has   = 1'b1;
                    pend_next.store = 1'b1;
                end
            end
        end

        // Advance the scan; a miss after the last stored key emits the value
        if (ram_re)
        begin
            rd_idx_next   = rd_idx_reg + 1'b1;
            cmp_pend_next = 1'b1;
        end
        if (state_reg == ardf_pkg::ST_SEARCH && scan_end)
        begin
            pend_next.has   = 1'b1;
            pend_next.ovf   = full;
            pend_next.store = !full;
        end

        // Commit the item to the row state
        if (commit)
        begin
            if (pend_reg.store)
            begin
                seen_count_next = seen_count_reg + 1'b1;
            end
            if (pend_reg.has && pend_reg.is_null)
            begin
                null_seen_next = 1'b1;
            end
            if (pend_reg.rend)
            begin
                seen_count_next = '0;
                null_seen_next  = 1'b0;
            end
            if (pend_reg.has)
            begin
                offset_next = offset_reg + 1'b1;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_has_next    = out_has_reg;
        out_value_next  = out_value_reg;
        out_null_next   = out_null_reg;
        out_rend_next   = out_rend_reg;
        out_rnull_next  = out_rnull_reg;
        out_offset_next = out_offset_reg;
        out_ovf_next    = out_ovf_reg;
        if (commit && has_res)
        begin
            out_valid_next  = 1'b1;
            out_has_next    = pend_reg.has;
            out_value_next  = (pend_reg.has && !pend_reg.is_null) ? val_reg : '0;
            out_null_next   = pend_reg.is_null;
            out_rend_next   = pend_reg.rend;
            out_rnull_next  = pend_reg.rnull;
            out_offset_next = offset_next;
            out_ovf_next    = pend_reg.ovf;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ardf_pkg::ST_IDLE;
            etype_reg      <= ardf_pkg::ET_RESET;
            seen_count_reg <= '0;
            null_seen_reg  <= 1'b0;
            offset_reg     <= '0;
            rd_idx_reg     <= '0;
            cmp_pend_reg   <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                etype_reg <= cfg_wdata;
            end
            seen_count_reg <= seen_count_next;
            null_seen_reg  <= null_seen_next;
            offset_reg     <= offset_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_pend_reg   <= cmp_pend_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        val_reg        <= val_next;
        out_has_reg    <= out_has_next;
        out_value_reg  <= out_value_next;
        out_null_reg   <= out_null_next;
        out_rend_reg   <= out_rend_next;
        out_rnull_reg  <= out_rnull_next;
        out_offset_reg <= out_offset_next;
        out_ovf_reg    <= out_ovf_next;
    end

    // Drive the output channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.has_element  = out_has_reg;
    assign out_ch.out_value    = out_value_reg;
    assign out_ch.out_null     = out_null_reg;
    assign out_ch.row_end      = out_rend_reg;
    assign out_ch.row_is_null  = out_rnull_reg;
    assign out_ch.end_offset   = out_offset_reg;
    assign out_ch.set_overflow = out_ovf_reg;

`ifndef SYNTH
    // The key count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_count_reg <= ardf_pkg::CNT_W'(ardf_pkg::SET_DEPTH))
        else $error("seen key count beyond store depth");

    // A key is only written once its scan is over, and never into a full store
    a_write_safe: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ardf_pkg::ST_FINISH) && !full)
        else $error("key store written during a scan or when full");

    // The running offset moves only when an element is committed
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (offset_reg != $past(offset_reg)) |-> $past(commit && pend_reg.has))
        else $error("output offset changed without an emitted element");

    // A loaded result always carries an element or a row end
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_has_reg || out_rend_reg))
        else $error("empty result presented");
`endif

endmodule

`default_nettype wire

/* sim/tb_array_row_distinct_filter.sv */
// Self-checking testbench of the array row distinct filter: predicts each row result.
`default_nettype none

module tb_array_row_distinct_filter;

    localparam int RUN_LIMIT   = 10_000_000;
    localparam int SETTLE_CYC  = ardf_pkg::SET_DEPTH + 8;
    localparam int END_WAIT    = 100_000;
    localparam int PRINT_LIMIT = 50;

    // One row result as the block should present it
    typedef struct packed {
        logic                          has_element;
        logic [ardf_pkg::KEY_W-1:0]    out_value;
        logic                          out_null;
        logic                          row_end;
        logic                          row_is_null;
        logic [ardf_pkg::OFS_W-1:0]    end_offset;
        logic                          set_overflow;
    } filter_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [ardf_pkg::ET_W-1:0]    cfg_wdata;

    ardf_in_if  in_ch ();
    ardf_out_if out_ch ();

    array_row_distinct_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predicted state of the filter
    logic [ardf_pkg::ET_W-1:0]    cur_etype;
    logic [ardf_pkg::KEY_W-1:0]   key_store [ardf_pkg::SET_DEPTH];
    int                           key_count;
    logic                         null_taken;
    logic [ardf_pkg::OFS_W-1:0]   emit_offset;

    filter_result_t    filtered_due [$];
    int                mismatch_count;
    int                result_idx;

    // Sender and receiver pacing
    bit                tx_idle_on;
    int                burst_left;
    int                rx_hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Compare width of each element type; the spare code compares like long
    function automatic logic [ardf_pkg::KEY_W-1:0] cmp_mask(
        input logic [ardf_pkg::ET_W-1:0] et);
        case (et)
            ardf_pkg::ET_BYTE:                     return 64'hFF;
            ardf_pkg::ET_SHORT:                    return 64'hFFFF;
            ardf_pkg::ET_INT, ardf_pkg::ET_FLOAT:  return 64'hFFFF_FFFF;
            ardf_pkg::ET_BOOL:                     return 64'h1;
            default:                               return '1;
        endcase
    endfunction

    // Normalise to a compare key: one NaN, one zero for the floating types
    function automatic logic [ardf_pkg::KEY_W-1:0] norm_key(
        input logic [ardf_pkg::ET_W-1:0]  et,
        input logic [ardf_pkg::KEY_W-1:0] raw);
        logic [ardf_pkg::KEY_W-1:0] k;
        k = raw & cmp_mask(et);
        if (et == ardf_pkg::ET_FLOAT)
        begin
            if ((&k[30:23]) && (|k[22:0]))
                k = 64'h7FC0_0000;
            else if (k == 64'h8000_0000)
                k = '0;
        end
        else if (et == ardf_pkg::ET_DOUBLE)
        begin
            if ((&k[62:52]) && (|k[51:0]))
                k = 64'h7FF8_0000_0000_0000;
            else if (k == 64'h8000_0000_0000_0000)
                k = '0;
        end
        return k;
    endfunction

    function automatic logic [ardf_pkg::KEY_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Draw a raw value, weighted towards zeros, signed zeros, NaNs and infinities
    function automatic logic [ardf_pkg::KEY_W-1:0] pick_raw(
        input logic [ardf_pkg::ET_W-1:0] et);
        logic [ardf_pkg::KEY_W-1:0] v;
        v = rand64();
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2:
            begin
                if (et == ardf_pkg::ET_FLOAT)
                    v = 64'h8000_0000;
                else
                    v = 64'h8000_0000_0000_0000;
            end
            3:
            begin
                if (et == ardf_pkg::ET_FLOAT)
                begin
                    v[30:23] = '1;
                    if (v[22:0] == '0)
                        v[0] = 1'b1;
                end
                else
                begin
                    v[62:52] = '1;
                    if (v[51:0] == '0)
                        v[0] = 1'b1;
                end
            end
            4:
            begin
                if (et == ardf_pkg::ET_FLOAT)
                    v[30:0] = 31'h7F80_0000;
                else
                    v[62:0] = {11'h7FF, 52'd0};
            end
            default: ;
        endcase
        return v;
    endfunction

    // Work out the row result of one accepted transfer, if it causes one
    task automatic dedup_predict(input logic [ardf_pkg::CMD_W-1:0] cmd, input logic nul,
                                 input logic [ardf_pkg::KEY_W-1:0] val, input logic last);
        filter_result_t             r;
        logic [ardf_pkg::KEY_W-1:0] key;
        logic                       hit;
        int                         i;
        r = '0;
        if (cmd == ardf_pkg::CMD_NONE)
            return;
        if (cmd == ardf_pkg::CMD_EMPTY || cmd == ardf_pkg::CMD_NULL)
        begin
            key_count      = 0;
            null_taken     = 1'b0;
            r.row_end      = 1'b1;
            r.row_is_null  = (cmd == ardf_pkg::CMD_NULL);
        end
        else
        begin
            if (nul)
            begin
                if (!null_taken)
                begin
                    null_taken    = 1'b1;
                    r.has_element = 1'b1;
                    r.out_null    = 1'b1;
                end
            end
            else
            begin
                key = norm_key(cur_etype, val);
                hit = 1'b0;
                for (i = 0; i < key_count; i++)
                    if (key_store[i] == key)
                        hit = 1'b1;
                if (!hit)
                begin
                    r.has_element = 1'b1;
                    r.out_value   = val & cmp_mask(cur_etype);
                    if (key_count < ardf_pkg::SET_DEPTH)
                    begin
                        key_store[key_count] = key;
                        key_count++;
                    end
                    else
                        r.set_overflow = 1'b1;
                end
            end
            if (last)
            begin
                r.row_end  = 1'b1;
                key_count  = 0;
                null_taken = 1'b0;
            end
            if (!r.has_element && !r.row_end)
                return;
        end
        if (r.has_element)
            emit_offset++;
        r.end_offset = emit_offset;
        filtered_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log short when something is badly wrong
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [ardf_pkg::KEY_W-1:0] got,
                               input logic [ardf_pkg::KEY_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      result_idx, name, got, want));
    endtask

    task automatic take_result();
        filter_result_t want;
        if (filtered_due.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with none pending", result_idx));
            result_idx++;
            return;
        end
        want = filtered_due.pop_front();
        check_field("has_element",  ardf_pkg::KEY_W'(out_ch.has_element),
                    ardf_pkg::KEY_W'(want.has_element));
        check_field("out_value",    out_ch.out_value, want.out_value);
        check_field("out_null",     ardf_pkg::KEY_W'(out_ch.out_null),
                    ardf_pkg::KEY_W'(want.out_null));
        check_field("row_end",      ardf_pkg::KEY_W'(out_ch.row_end),
                    ardf_pkg::KEY_W'(want.row_end));
        check_field("row_is_null",  ardf_pkg::KEY_W'(out_ch.row_is_null),
                    ardf_pkg::KEY_W'(want.row_is_null));
        check_field("end_offset",   ardf_pkg::KEY_W'(out_ch.end_offset),
                    ardf_pkg::KEY_W'(want.end_offset));
        check_field("set_overflow", ardf_pkg::KEY_W'(out_ch.set_overflow),
                    ardf_pkg::KEY_W'(want.set_overflow));
        result_idx++;
    endtask

    // Check every output transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            take_result();
    end

    // Receiver: runs of steady, light, heavy and periodic stalling, plus requested hold-offs
    initial
    begin : rx_pacing
        int mode;
        int run_left;
        int hold_left;
        mode      = 0;
        run_left  = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req != 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(10, 150);
                end
                run_left--;
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: out_ch.ready <= (run_left % 5 != 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until its transfer; gap between bursts
    task automatic send_item(input logic [ardf_pkg::CMD_W-1:0] cmd, input logic nul,
                             input logic [ardf_pkg::KEY_W-1:0] val, input logic last);
        if (tx_idle_on && burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.elem_null  <= nul;
        in_ch.elem_value <= val;
        in_ch.row_last   <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        dedup_predict(cmd, nul, val, last);
        if (burst_left != 0)
            burst_left--;
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (filtered_due.size() != 0);
    endtask

    // Write the element type once the block is idle
    task automatic set_element_type(input logic [ardf_pkg::ET_W-1:0] et);
        drain_results();
        // an element that gives no result may still be searching
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= et;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_etype = et;
    endtask

    // Reset type int: duplicates, nulls, ignored command, abandoned row, null row
    task automatic test_int_rows();
        send_item(ardf_pkg::CMD_ELEM,  1'b0, 64'h0,                    1'b0);
        send_item(ardf_pkg::CMD_ELEM,  1'b0, 64'hFFFF_FFFF_0000_0000,  1'b0);
        send_item(ardf_pkg::CMD_ELEM,  1'b0, 64'hFFFF_FFFF_FFFF_FFFF,  1'b0);
        send_item(ardf_pkg::CMD_ELEM,  1'b1, rand64(),                 1'b0);
        send_item(ardf_pkg::CMD_ELEM,  1'b1, rand64(),                 1'b0);
        send_item(ardf_pkg::CMD_NONE,  1'b0, rand64(),                 1'b1);
        send_item(ardf_pkg::CMD_ELEM,  1'b0, 64'h0000_0000_FFFF_FFFF,  1'b1);
        send_item(ardf_pkg::CMD_ELEM,  1'b0, 64'h5,                    1'b0);
        send_item(ardf_pkg::CMD_EMPTY, 1'b0, rand64(),                 1'b0);
        send_item(ardf_pkg::CMD_ELEM,  1'b0, 64'h5,                    1'b1);
        send_item(ardf_pkg::CMD_NULL,  1'b1, rand64(),                 1'b1);
        send_item(ardf_pkg::CMD_ELEM,  1'b1, 64'h0,                    1'b1);
    endtask

    // Float: signed zeros fold, NaNs fold, infinities stay apart, upper half ignored
    task automatic test_float_keys();
        set_element_type(ardf_pkg::ET_FLOAT);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h0000_0000,           1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h8000_0000,           1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h7FC0_0001,           1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'hFF80_0001,           1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h7F80_0000,           1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'hFF80_0000,           1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'hABCD_0123_8000_0000, 1'b1);
    endtask

    task automatic test_double_keys();
        set_element_type(ardf_pkg::ET_DOUBLE);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h8000_0000_0000_0000, 1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h0,                   1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'hFFF0_0000_0000_0001, 1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h7FF8_0000_0000_0000, 1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, 64'h7FF0_0000_0000_0000, 1'b1);
    endtask

    // Fill the key set, then stored, new and repeated-new values past the limit
    task automatic test_set_overflow(input logic [ardf_pkg::ET_W-1:0] et);
        logic [ardf_pkg::KEY_W-1:0] vals [ardf_pkg::SET_DEPTH+1];
        int                         base;
        int                         i;
        set_element_type(et);
        base = $urandom_range(0, 255);
        // distinct low bytes keep every value distinct under any width of a byte or more
        for (i = 0; i <= ardf_pkg::SET_DEPTH; i++)
            vals[i] = {$urandom(), 24'($urandom()), 8'(base + 3 * i)};
        for (i = 0; i < ardf_pkg::SET_DEPTH; i++)
            send_item(ardf_pkg::CMD_ELEM, 1'b0, vals[i], 1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, vals[5],                   1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, vals[ardf_pkg::SET_DEPTH], 1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, vals[ardf_pkg::SET_DEPTH], 1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b1, rand64(),                  1'b0);
        send_item(ardf_pkg::CMD_ELEM, 1'b0, vals[10],                  1'b1);
    endtask

    // Hold the receiver off while items keep coming, so the block stalls its input
    task automatic test_output_hold();
        int i;
        set_element_type(ardf_pkg::ET_LONG);
        tx_idle_on  = 1'b0;
        rx_hold_req = 300;
        for (i = 0; i < 24; i++)
            send_item(ardf_pkg::CMD_ELEM, 1'b0, rand64(), i == 23);
        tx_idle_on = 1'b1;
        drain_results();
    endtask

    // Mostly well-formed rows from small value pools, with broken rows and noise
    task automatic test_random_rows(input logic [ardf_pkg::ET_W-1:0] et, input int n_items);
        logic [ardf_pkg::KEY_W-1:0] pool [8];
        logic [ardf_pkg::KEY_W-1:0] v;
        logic [ardf_pkg::CMD_W-1:0] noise_cmd;
        int                         pool_n;
        int                         row_len;
        int                         sent;
        int                         kind;
        int                         k;
        bit                         broken;
        set_element_type(et);
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 5)
            begin
                send_item(ardf_pkg::CMD_EMPTY, 1'($urandom_range(0, 1)), rand64(),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else if (kind < 10)
            begin
                send_item(ardf_pkg::CMD_NULL, 1'($urandom_range(0, 1)), rand64(),
                          1'($urandom_range(0, 1)));
                sent++;
            end
            else if (kind < 14)
            begin
                noise_cmd = ardf_pkg::CMD_W'($urandom_range(0, 3));
                send_item(noise_cmd, 1'($urandom_range(0, 1)), rand64(),
                          1'($urandom_range(0, 1)));
                if (noise_cmd != ardf_pkg::CMD_NONE)
                    sent++;
            end
            else if (kind < 16)
                drain_results();
            else
            begin
                pool_n  = $urandom_range(1, 8);
                for (k = 0; k < pool_n; k++)
                    pool[k] = pick_raw(et);
                row_len = $urandom_range(1, 12);
                broken  = ($urandom_range(0, 9) == 0);
                for (k = 0; k < row_len; k++)
                begin
                    v = pool[$urandom_range(0, pool_n - 1)];
                    if ($urandom_range(0, 1) != 0)
                        v = v ^ (rand64() & ~cmp_mask(et));
                    send_item(ardf_pkg::CMD_ELEM, $urandom_range(0, 9) == 0, v,
                              (k == row_len - 1) && !broken);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin : main_seq
        int p;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= ardf_pkg::CMD_NONE;
        in_ch.elem_null  <= 1'b0;
        in_ch.elem_value <= '0;
        in_ch.row_last   <= 1'b0;
        cur_etype        = ardf_pkg::ET_RESET;
        key_count        = 0;
        null_taken       = 1'b0;
        emit_offset      = '0;
        mismatch_count   = 0;
        result_idx       = 0;
        tx_idle_on       = 1'b1;
        burst_left       = 0;
        rx_hold_req      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_int_rows();
        test_float_keys();
        test_double_keys();
        test_set_overflow(ardf_pkg::ET_BYTE);
        test_set_overflow(ardf_pkg::ET_LONG);
        test_output_hold();
        // every element type code, the spare one included, then the extremes again
        for (p = 0; p < 8; p++)
            test_random_rows(ardf_pkg::ET_W'(p), 100);
        test_random_rows(ardf_pkg::ET_BOOL, 100);
        test_random_rows(ardf_pkg::ET_BYTE, 100);

        // Drain, then allow the block to settle
        in_ch.valid <= 1'b0;
        for (p = 0; p < END_WAIT && filtered_due.size() != 0; p++)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (filtered_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", filtered_due.size()));

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/ardf_pkg.sv
hdl/ardf_in_if.sv
hdl/ardf_out_if.sv
hdl/ardf_ram.sv
hdl/array_row_distinct_filter.sv
sim/tb_array_row_distinct_filter.sv
